FILE: src/aol_pkg.sv
// Shared types and constants for the A* open list table.
// Depends on nothing; every other file of the block uses it.
`default_nettype none

package aol_pkg;

  localparam int DEPTH_DEF       = 64;
  localparam int COORD_WIDTH_DEF = 10;
  localparam int FIELD_COORD_W   = 10;
  localparam int COST_W          = 16;
  localparam int OCC_W           = 7;

  localparam logic [1:0] ACT_INSERT = 2'd0;
  localparam logic [1:0] ACT_UPDATE = 2'd1;
  localparam logic [1:0] ACT_POP    = 2'd2;

  localparam logic [1:0] ST_DONE    = 2'd0;
  localparam logic [1:0] ST_FULL    = 2'd1;
  localparam logic [1:0] ST_EMPTY   = 2'd2;
  localparam logic [1:0] ST_NO_UPD  = 2'd3;

  typedef enum logic {
    S_IDLE,
    S_BUSY
  } fsm_state_t;

  typedef struct packed {
    logic [1:0]               action;
    logic [FIELD_COORD_W-1:0] node_x;
    logic [FIELD_COORD_W-1:0] node_y;
    logic [COST_W-1:0]        cost_g;
    logic [COST_W-1:0]        cost_h;
    logic [FIELD_COORD_W-1:0] parent_x;
    logic [FIELD_COORD_W-1:0] parent_y;
  } req_word_t;

  typedef struct packed {
    logic [1:0]               status;
    logic [FIELD_COORD_W-1:0] out_x;
    logic [FIELD_COORD_W-1:0] out_y;
    logic [COST_W-1:0]        out_g;
    logic [COST_W-1:0]        out_h;
    logic [FIELD_COORD_W-1:0] out_parent_x;
    logic [FIELD_COORD_W-1:0] out_parent_y;
    logic [OCC_W-1:0]         occupancy;
  } res_word_t;

  typedef struct packed {
    logic       capture;
    logic       apply;
    logic [1:0] action;
  } cell_ctl_t;

endpackage

`default_nettype wire

FILE: src/aol_if.sv
// Valid/ready channel interfaces for the request and result words.
// Depends on aol_pkg for the word types.
`default_nettype none

interface aol_req_if;
  logic              valid;
  logic              ready;
  aol_pkg::req_word_t data;

  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

interface aol_res_if;
  logic              valid;
  logic              ready;
  aol_pkg::res_word_t data;

  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

`default_nettype wire

FILE: src/astar_open_list_table.sv
// Top level of the A* open list: a chain of entry cells, a minimum tree and the sequencer.
// Depends on aol_pkg, aol_if, aol_cell and aol_min_tree.
//
//   channel  direction  word        accepted when
//   req      in         req_word_t  req.valid && req.ready
//   res      out        res_word_t  res.valid && res.ready
//
// Insert and update: cells compare on the accepting edge, then shift or overwrite once the result is free.
// A pop waits until the registered minimum tree, clog2(DEPTH) levels deep, has settled after
// the last applied word; a pop on an empty list does not wait for the tree.
// A result that is not taken holds back the next update of the list.
// Synchronous reset empties the list at once; no clearing pass is needed.
`default_nettype none

module astar_open_list_table #(
  parameter int DEPTH       = aol_pkg::DEPTH_DEF,
  parameter int COORD_WIDTH = aol_pkg::COORD_WIDTH_DEF
) (
  input  logic       clk,
  input  logic       rst,
  aol_req_if.sink    req,
  aol_res_if.source  res
);
  import aol_pkg::*;

  localparam int CW    = (COORD_WIDTH < FIELD_COORD_W) ? COORD_WIDTH : FIELD_COORD_W;
  localparam int EW    = 4 * CW + 2 * COST_W;
  localparam int IW    = $clog2(DEPTH);
  localparam int CNT_W = $clog2(DEPTH + 1);
  localparam int SW    = $clog2(IW + 1);

  fsm_state_t       state;
  fsm_state_t       state_next;
  logic [1:0]       cur_action;
  logic [EW-1:0]    cur_entry;
  logic [EW-1:0]    port_entry;
  logic [EW-1:0]    cand;
  logic [CNT_W-1:0] count;
  logic [CNT_W-1:0] count_next;
  logic [SW-1:0]    settle;
  logic             res_valid;
  res_word_t        res_data;
  res_word_t        res_next;
  logic             out_free;
  logic             go;
  logic             modify;
  logic             accept;
  cell_ctl_t        ctl;

  logic [DEPTH-1:0] cell_valid;
  logic [EW-1:0]    cell_entry [DEPTH];
  logic [DEPTH:0]   chain;
  logic [DEPTH-1:0] hit;

  logic             root_valid;
  logic [IW-1:0]    root_idx;
  logic [EW-1:0]    root_entry;

  assign accept    = req.valid && req.ready;
  assign req.ready = (state == S_IDLE);
  assign res.valid = res_valid;
  assign res.data  = res_data;
  assign out_free  = !res_valid || res.ready;

  assign port_entry = {req.data.node_x[CW-1:0], req.data.node_y[CW-1:0],
                       req.data.parent_x[CW-1:0], req.data.parent_y[CW-1:0],
                       req.data.cost_g, req.data.cost_h};
  assign cand = (state == S_IDLE) ? port_entry : cur_entry;

  assign ctl.capture = accept;
  assign ctl.apply   = go && modify;
  assign ctl.action  = (state == S_IDLE) ? req.data.action : cur_action;

  assign chain[0] = 1'b0;

  for (genvar i = 0; i < DEPTH; i++) begin : g_cell
    logic          lv;
    logic [EW-1:0] le;
    logic          rv;
    logic [EW-1:0] re;

    if (i == 0) begin : g_head
      assign lv = 1'b0;
      assign le = '0;
    end else begin : g_mid
      assign lv = cell_valid[i-1];
      assign le = cell_entry[i-1];
    end
    if (i == DEPTH - 1) begin : g_tail
      assign rv = 1'b0;
      assign re = '0;
    end else begin : g_body
      assign rv = cell_valid[i+1];
      assign re = cell_entry[i+1];
    end

    aol_cell #(
      .EW (EW)
    ) u_cell (
      .clk         (clk),
      .rst         (rst),
      .ctl         (ctl),
      .cand        (cand),
      .left_valid  (lv),
      .left_entry  (le),
      .right_valid (rv),
      .right_entry (re),
      .take_right  (IW'(i) >= root_idx),
      .before_in   (chain[i]),
      .before_out  (chain[i+1]),
      .hit         (hit[i]),
      .valid       (cell_valid[i]),
      .entry       (cell_entry[i])
    );
  end

  aol_min_tree #(
    .DEPTH (DEPTH),
    .EW    (EW)
  ) u_min_tree (
    .clk        (clk),
    .leaf_valid (cell_valid),
    .leaf_entry (cell_entry),
    .root_valid (root_valid),
    .root_idx   (root_idx),
    .root_entry (root_entry)
  );

  always_comb begin
    state_next = state;
    go         = 1'b0;
    modify     = 1'b0;
    count_next = count;
    res_next   = '0;
    case (state)
      S_IDLE: begin
        if (req.valid) begin
          state_next = S_BUSY;
        end
      end
      S_BUSY: begin
        if (out_free && (cur_action != ACT_POP || count == '0 || settle == '0)) begin
          go         = 1'b1;
          state_next = S_IDLE;
          case (cur_action)
            ACT_INSERT: begin
              if (count == CNT_W'(DEPTH)) begin
                res_next.status = ST_FULL;
              end else begin
                modify     = 1'b1;
                count_next = count + 1'b1;
              end
            end
            ACT_UPDATE: begin
              modify          = 1'b1;
              res_next.status = (|hit) ? ST_DONE : ST_NO_UPD;
            end
            ACT_POP: begin
              if (count == '0) begin
                res_next.status = ST_EMPTY;
              end else begin
                modify                = 1'b1;
                count_next            = count - 1'b1;
                res_next.out_x        = FIELD_COORD_W'(root_entry[EW-1 -: CW]);
                res_next.out_y        = FIELD_COORD_W'(root_entry[EW-CW-1 -: CW]);
                res_next.out_parent_x = FIELD_COORD_W'(root_entry[EW-2*CW-1 -: CW]);
                res_next.out_parent_y = FIELD_COORD_W'(root_entry[EW-3*CW-1 -: CW]);
                res_next.out_g        = root_entry[2*COST_W-1:COST_W];
                res_next.out_h        = root_entry[COST_W-1:0];
              end
            end
            default: begin
              res_next.status = ST_DONE;
            end
          endcase
          res_next.occupancy = OCC_W'(count_next);
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      count     <= '0;
      settle    <= SW'(IW);
      res_valid <= 1'b0;
    end else begin
      count <= count_next;
      if (ctl.apply) begin
        settle <= SW'(IW);
      end else if (settle != '0) begin
        settle <= settle - 1'b1;
      end
      if (go) begin
        res_valid <= 1'b1;
      end else if (res.ready) begin
        res_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      cur_action <= req.data.action;
      cur_entry  <= port_entry;
    end
    if (go) begin
      res_data <= res_next;
    end
  end

`ifndef ASSERT_OFF
  a_count_matches_valid: assert property (@(posedge clk) disable iff (rst)
    $countones(cell_valid) == int'(count))
    else $error("entry count disagrees with the cell valid bits");

  a_pop_root_valid: assert property (@(posedge clk) disable iff (rst)
    (go && cur_action == ACT_POP && count != '0) |-> root_valid)
    else $error("pop taken without a valid minimum");

  a_one_word_per_accept: assert property (@(posedge clk) disable iff (rst)
    accept |=> !req.ready)
    else $error("second word accepted while one is in progress");

  a_result_back_to_idle: assert property (@(posedge clk) disable iff (rst)
    go |=> (state == S_IDLE && res.valid))
    else $error("result written but sequencer not back to idle");
`endif

endmodule

`default_nettype wire

FILE: src/aol_cell.sv
// One slot of the open list chain: holds an entry, its valid bit and the compare flags.
// Depends on aol_pkg; neighbours are wired together by the top level.
`default_nettype none

module aol_cell #(
  parameter int EW = 72
) (
  input  logic              clk,
  input  logic              rst,
  input  aol_pkg::cell_ctl_t ctl,
  input  logic [EW-1:0]     cand,
  input  logic              left_valid,
  input  logic [EW-1:0]     left_entry,
  input  logic              right_valid,
  input  logic [EW-1:0]     right_entry,
  input  logic              take_right,
  input  logic              before_in,
  output logic              before_out,
  output logic              hit,
  output logic              valid,
  output logic [EW-1:0]     entry
);
  import aol_pkg::*;

  localparam int CW = (EW - 2 * COST_W) / 4;

  logic              flag;
  logic              cheaper;
  logic              flag_next;
  logic              cheaper_next;
  logic [COST_W:0]   key;
  logic [COST_W:0]   sum;
  logic              pos_match;
  logic              valid_next;
  logic [EW-1:0]     entry_next;

  always_comb begin
    key = {1'b0, cand[2*COST_W-1:COST_W]} + {1'b0, cand[COST_W-1:0]};
    sum = {1'b0, entry[2*COST_W-1:COST_W]} + {1'b0, entry[COST_W-1:0]};
    pos_match = (entry[EW-1 -: 2*CW] == cand[EW-1 -: 2*CW]);
    cheaper_next = (entry[2*COST_W-1:COST_W] > cand[2*COST_W-1:COST_W]);
    case (ctl.action)
      ACT_INSERT: flag_next = !valid || (key <= sum);
      ACT_UPDATE: flag_next = valid && pos_match;
      default:    flag_next = 1'b0;
    endcase
  end

  assign before_out = before_in | flag;
  assign hit        = flag && !before_in && cheaper;

  always_comb begin
    valid_next = valid;
    entry_next = entry;
    if (ctl.apply) begin
      case (ctl.action)
        ACT_INSERT: begin
          if (before_in) begin
            valid_next = left_valid;
            entry_next = left_entry;
          end else if (flag) begin
            valid_next = 1'b1;
            entry_next = cand;
          end
        end
        ACT_UPDATE: begin
          if (hit) begin
            entry_next = cand;
          end
        end
        ACT_POP: begin
          if (take_right) begin
            valid_next = right_valid;
            entry_next = right_entry;
          end
        end
        default: begin
          valid_next = valid;
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.capture) begin
      flag    <= flag_next;
      cheaper <= cheaper_next;
    end
    entry <= entry_next;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= 1'b0;
    end else begin
      valid <= valid_next;
    end
  end

endmodule

`default_nettype wire

FILE: src/aol_min_tree.sv
// Registered tournament tree that finds the entry with least g+h, then least h,
// then lowest slot. Depends on aol_pkg for the cost width.
`default_nettype none

module aol_min_tree #(
  parameter int DEPTH = 64,
  parameter int EW    = 72
) (
  input  logic                     clk,
  input  logic [DEPTH-1:0]         leaf_valid,
  input  logic [EW-1:0]            leaf_entry [DEPTH],
  output logic                     root_valid,
  output logic [$clog2(DEPTH)-1:0] root_idx,
  output logic [EW-1:0]            root_entry
);
  import aol_pkg::*;

  localparam int IW     = $clog2(DEPTH);
  localparam int LEAVES = 1 << IW;

  logic          lf_v [LEAVES];
  logic [IW-1:0] lf_i [LEAVES];
  logic [EW-1:0] lf_e [LEAVES];
  logic          nd_v [LEAVES];
  logic [IW-1:0] nd_i [LEAVES];
  logic [EW-1:0] nd_e [LEAVES];

  function automatic logic right_better(input logic lv, input logic [EW-1:0] le,
                                        input logic rv, input logic [EW-1:0] re);
    logic [COST_W:0] ls;
    logic [COST_W:0] rs;
    ls = {1'b0, le[2*COST_W-1:COST_W]} + {1'b0, le[COST_W-1:0]};
    rs = {1'b0, re[2*COST_W-1:COST_W]} + {1'b0, re[COST_W-1:0]};
    return rv && (!lv || (rs < ls) || ((rs == ls) && (re[COST_W-1:0] < le[COST_W-1:0])));
  endfunction

  for (genvar j = 0; j < LEAVES; j++) begin : g_leaf
    if (j < DEPTH) begin : g_real
      assign lf_v[j] = leaf_valid[j];
      assign lf_e[j] = leaf_entry[j];
    end else begin : g_pad
      assign lf_v[j] = 1'b0;
      assign lf_e[j] = '0;
    end
    assign lf_i[j] = IW'(j);
  end

  for (genvar k = 1; k < LEAVES; k++) begin : g_node
    logic          av;
    logic          bv;
    logic [IW-1:0] ai;
    logic [IW-1:0] bi;
    logic [EW-1:0] ae;
    logic [EW-1:0] be;

    if (2 * k >= LEAVES) begin : g_from_leaf
      assign av = lf_v[2*k-LEAVES];
      assign ai = lf_i[2*k-LEAVES];
      assign ae = lf_e[2*k-LEAVES];
      assign bv = lf_v[2*k+1-LEAVES];
      assign bi = lf_i[2*k+1-LEAVES];
      assign be = lf_e[2*k+1-LEAVES];
    end else begin : g_from_node
      assign av = nd_v[2*k];
      assign ai = nd_i[2*k];
      assign ae = nd_e[2*k];
      assign bv = nd_v[2*k+1];
      assign bi = nd_i[2*k+1];
      assign be = nd_e[2*k+1];
    end

    always_ff @(posedge clk) begin
      if (right_better(av, ae, bv, be)) begin
        nd_v[k] <= bv;
        nd_i[k] <= bi;
        nd_e[k] <= be;
      end else begin
        nd_v[k] <= av;
        nd_i[k] <= ai;
        nd_e[k] <= ae;
      end
    end
  end

  assign nd_v[0] = 1'b0;
  assign nd_i[0] = '0;
  assign nd_e[0] = '0;

  assign root_valid = nd_v[1];
  assign root_idx   = nd_i[1];
  assign root_entry = nd_e[1];

endmodule

`default_nettype wire
